FILE: design/partition_fit_allocator_defines.svh
// Assertion macros shared by the partition allocator RTL.
`ifndef PARTITION_FIT_ALLOCATOR_DEFINES_SVH
`define PARTITION_FIT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define PFA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define PFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/pfa_pkg.sv
// Types, codes and constants of the partition fit allocator.
package pfa_pkg;

    localparam int NUM_PARTITIONS = 10;
    localparam int SIZE_BITS      = 8;
    localparam int IDX_W          = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
    localparam int REQ_W          = 8;
    localparam int CMP_W          = (SIZE_BITS > REQ_W) ? SIZE_BITS : REQ_W;

    typedef logic [SIZE_BITS-1:0] size_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [REQ_W-1:0]     req_t;
    typedef logic [1:0]           op_t;
    typedef logic [1:0]           policy_t;
    typedef logic [1:0]           status_t;
    typedef logic [3:0]           pos_t;

    // Operation codes.
    localparam op_t OP_CHECK = 2'd0;
    localparam op_t OP_ALLOC = 2'd1;
    localparam op_t OP_FREE  = 2'd2;

    // Placement policy codes.
    localparam policy_t POL_FIRST = 2'd0;
    localparam policy_t POL_BEST  = 2'd1;
    localparam policy_t POL_WORST = 2'd2;
    localparam policy_t POL_BAD   = 2'd3;

    // Result status codes.
    localparam status_t ST_OK     = 2'd0;
    localparam status_t ST_NOFIT  = 2'd1;
    localparam status_t ST_BADPOL = 2'd2;
    localparam status_t ST_RANGE  = 2'd3;

    // Partition capacities; entries past the tenth are empty.
    localparam logic [7:0] CAP_TABLE [0:15] = '{
        8'd5, 8'd6, 8'd4, 8'd7, 8'd3, 8'd8, 8'd2, 8'd9,
        8'd1, 8'd5, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic    clear;
        logic    step;
        policy_t policy;
    } scan_ctrl_t;

    typedef struct packed {
        logic found;
        idx_t pick;
    } scan_result_t;

    // Capacity of one partition, resized to the size width.
    function automatic size_t cap_of(input idx_t i);
        logic [3:0] tidx;
        tidx = 4'(i);
        return size_t'(CAP_TABLE[tidx]);
    endfunction

endpackage

FILE: design/pfa_scan_unit.sv
// Shared compare unit that weighs one partition per cycle against the best pick so far.
module pfa_scan_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pfa_pkg::scan_ctrl_t   ctrl,
    input  pfa_pkg::idx_t         idx,
    input  pfa_pkg::size_t        room,
    input  pfa_pkg::req_t         request,
    output pfa_pkg::scan_result_t result
);
    import pfa_pkg::*;

    logic  found_reg, found_next;
    idx_t  pick_reg, pick_next;
    size_t pick_room_reg, pick_room_next;
    logic  fits;
    logic  better;

    // A partition fits when its free room covers the request.
    assign fits = CMP_W'(room) >= CMP_W'(request);

    // Policy decides whether this partition beats the current pick; ties keep the lower index.
    always_comb
    begin
        unique case (ctrl.policy)
            POL_FIRST: better = !found_reg;
            POL_BEST:  better = !found_reg || (room < pick_room_reg);
            POL_WORST: better = !found_reg || (room > pick_room_reg);
            default:   better = 1'b0;
        endcase
    end

    // Next pick.
    always_comb
    begin
        found_next     = found_reg;
        pick_next      = pick_reg;
        pick_room_next = pick_room_reg;
        if (ctrl.clear)
        begin
            found_next = 1'b0;
        end
        else if (ctrl.step && fits && better)
        begin
            found_next     = 1'b1;
            pick_next      = idx;
            pick_room_next = room;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pick_reg      <= pick_next;
        pick_room_reg <= pick_room_next;
    end

    assign result.found = found_reg;
    assign result.pick  = pick_reg;

endmodule

FILE: design/partition_fit_allocator.sv
// Partition fit allocator: first, best or worst fit over a fixed set of partitions.
// Check and allocate latch the item, then weigh each partition in turn through the shared
// compare unit, then write back the result once the result register is free. Free and
// rejected operations skip the scan and go straight to write back. One item at a time;
// a new beat is taken while the previous result still waits. Reset clears all used
// amounts at once, which gives every partition its full capacity again.
`include "partition_fit_allocator_defines.svh"
module partition_fit_allocator (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pfa_pkg::op_t      operation,
    input  pfa_pkg::policy_t  policy,
    input  pfa_pkg::req_t     request_size,
    input  pfa_pkg::pos_t     position,
    output logic              out_valid,
    input  logic              out_ready,
    output pfa_pkg::status_t  status,
    output pfa_pkg::pos_t     chosen_position
);
    import pfa_pkg::*;

    state_t       state_reg, state_next;
    idx_t         idx_reg, idx_next;
    op_t          op_reg;
    policy_t      policy_reg;
    req_t         req_reg;
    pos_t         pos_reg;
    size_t        used_reg  [NUM_PARTITIONS];
    size_t        used_next [NUM_PARTITIONS];
    logic         out_valid_reg, out_valid_next;
    status_t      status_reg, status_next;
    pos_t         chosen_reg, chosen_next;
    scan_ctrl_t   scan_ctrl;
    scan_result_t scan_res;
    size_t        room;
    logic         accept;
    logic         searching;
    logic         pos_in_range;
    logic         err_out;
    logic         scan_idx_ok;

    assign accept       = in_valid && in_ready;
    assign in_ready     = (state_reg == ST_IDLE);
    assign searching    = ((op_reg == OP_CHECK) || (op_reg == OP_ALLOC)) &&
                          (policy_reg != POL_BAD);
    assign pos_in_range = {1'b0, pos_reg} < 5'(NUM_PARTITIONS);

    // Free room of the partition under scan.
    assign room = cap_of(idx_reg) - used_reg[idx_reg];

    pfa_scan_unit u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (scan_ctrl),
        .idx     (idx_reg),
        .room    (room),
        .request (req_reg),
        .result  (scan_res)
    );

    // Sequencer, write back and result register.
    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        status_next      = status_reg;
        chosen_next      = chosen_reg;
        used_next        = used_reg;
        scan_ctrl.clear  = 1'b0;
        scan_ctrl.step   = 1'b0;
        scan_ctrl.policy = policy_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                scan_ctrl.clear = 1'b1;
                idx_next        = '0;
                if (accept)
                begin
                    if (((operation == OP_CHECK) || (operation == OP_ALLOC)) &&
                        (policy != POL_BAD))
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN:
            begin
                scan_ctrl.step = 1'b1;
                if (idx_reg == idx_t'(NUM_PARTITIONS - 1))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + idx_t'(1);
                end
            end
            ST_FINISH:
            begin
                // Wait until the result register is free.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    chosen_next    = '0;
                    state_next     = ST_IDLE;
                    priority if (searching)
                    begin
                        if (!scan_res.found)
                        begin
                            status_next = ST_NOFIT;
                        end
                        else
                        begin
                            chosen_next = pos_t'(scan_res.pick);
                            if (op_reg == OP_ALLOC)
                            begin
                                used_next[scan_res.pick] =
                                    used_reg[scan_res.pick] + size_t'(req_reg);
                            end
                        end
                    end
                    else if (op_reg == OP_FREE)
                    begin
                        if (pos_in_range)
                        begin
                            used_next[pos_reg[IDX_W-1:0]] = '0;
                            chosen_next = pos_reg;
                        end
                        else
                        begin
                            status_next = ST_RANGE;
                        end
                    end
                    else
                    begin
                        status_next = ST_BADPOL;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            for (int i = 0; i < NUM_PARTITIONS; i++)
            begin
                used_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            used_reg      <= used_next;
        end
    end

    // Latched item and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= operation;
            policy_reg <= policy;
            req_reg    <= request_size;
            pos_reg    <= position;
        end
        status_reg <= status_next;
        chosen_reg <= chosen_next;
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign chosen_position = chosen_reg;

    // Terms used by the checks below.
    assign err_out     = out_valid && (status != ST_OK);
    assign scan_idx_ok = (idx_reg <= idx_t'(NUM_PARTITIONS - 1));

    // Checks on the sequencer and the partition state.
    `PFA_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready, "ready high after a beat")
    `PFA_ASSERT_NOW(a_zero_on_error, err_out, chosen_position == '0, "position on error")
    `PFA_ASSERT_NOW(a_scan_in_range, state_reg == ST_SCAN, scan_idx_ok, "scan past end")

    for (genvar g = 0; g < NUM_PARTITIONS; g++)
    begin : g_used_chk
        `PFA_ASSERT_NOW(a_used_le_cap, 1'b1, used_reg[g] <= cap_of(idx_t'(g)), "used over cap")
    end

endmodule
